### hdl/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg
// Types, constants and helpers shared by the integer field formatter modules.
// ----------------------------------------------------------------------------
package ifmt_pkg;

   // Conversion kinds. The unused code converts as unsigned decimal.
   localparam logic [1:0] KIND_SIGNED   = 2'd0;
   localparam logic [1:0] KIND_UNSIGNED = 2'd1;
   localparam logic [1:0] KIND_HEX      = 2'd2;

   // Field width limit and the most digits a 32-bit value can have.
   localparam int MAX_PAD    = 9;
   localparam int MAX_DIGITS = 10;

   // Reciprocal of ten: floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for 32-bit x.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          QUOT_BITS   = 64 - RECIP_SHIFT;

   // ASCII characters.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Input word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [3:0]  pad_width;
      logic        zero_pad;
   } req_type;

   // Result word: one character.
   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic digits_done;
      logic final_char;
   } status_type;

   // Maps a digit value of 0 to 15 to its lower-case ASCII character.
   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      logic [7:0] result;
      if (digit < 4'd10) begin
         result = CHAR_ZERO + {4'b0000, digit};
      end else begin
         result = CHAR_LOW_A + {4'b0000, digit} - 8'd10;
      end
      return result;
   endfunction

endpackage

### hdl/ifmt_ctrl.sv
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Controller: sequences load, digit extraction and character emission, and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module ifmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ifmt_pkg::status_type   status,
   output ifmt_pkg::cmd_type      cmd
);

   ifmt_pkg::state_type state_ff;
   ifmt_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   // The output register can take a word when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ifmt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ifmt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ifmt_pkg::ST_MUL;
            end
         end
         ifmt_pkg::ST_MUL: begin
            state_in = ifmt_pkg::ST_DIV;
         end
         ifmt_pkg::ST_DIV: begin
            state_in = status.digits_done ? ifmt_pkg::ST_EMIT : ifmt_pkg::ST_MUL;
         end
         ifmt_pkg::ST_EMIT: begin
            if (out_free && status.final_char) begin
               state_in = ifmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ifmt_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ifmt_pkg::ST_IDLE: cmd.load = req_valid;
         ifmt_pkg::ST_MUL:  cmd.mul  = 1'b1;
         ifmt_pkg::ST_DIV:  cmd.div  = 1'b1;
         ifmt_pkg::ST_EMIT: cmd.emit = out_free;
         default:           cmd      = '0;
      endcase
   end

   // Output valid: set by an emitted word, cleared when the word is taken.
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifmt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A word is never written over one that waits to be taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("ifmt_ctrl: emit while output word is stalled");

   // An accepted input always starts a multiply step.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ifmt_pkg::ST_MUL))
      else $error("ifmt_ctrl: accepted input did not start extraction");

   // Every multiply step is followed by its digit step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ifmt_pkg::ST_MUL) |=> (state_ff == ifmt_pkg::ST_DIV))
      else $error("ifmt_ctrl: multiply step not followed by digit step");

   // The final character ends the field and leaves a valid word behind.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.final_char) |=> (state_ff == ifmt_pkg::ST_IDLE && rsp_valid_ff))
      else $error("ifmt_ctrl: final character did not close the field");

endmodule

### hdl/ifmt_dpath.sv
// ----------------------------------------------------------------------------
// ifmt_dpath
// Datapath: magnitude, digit extraction by reciprocal multiply or nibble
// shift, digit store, and the character output register.
// ----------------------------------------------------------------------------
module ifmt_dpath (
   input  logic                  clock,
   input  ifmt_pkg::req_type     req_data,
   input  ifmt_pkg::cmd_type     cmd,
   output ifmt_pkg::status_type  status,
   output ifmt_pkg::rsp_type     rsp_data
);

   logic [31:0]                     val_ff;
   logic [31:0]                     val_in;
   logic [ifmt_pkg::QUOT_BITS-1:0]  quot_ff;
   logic [63:0]                     product;
   logic                            hex_ff;
   logic                            neg_ff;
   logic                            neg_in;
   logic                            zero_pad_ff;
   logic [3:0]                      width_ff;
   logic [3:0]                      nd_ff;
   logic [3:0]                      ptr_ff;
   logic [3:0]                      pad_left_ff;
   logic [3:0]                      digit_ff [ifmt_pkg::MAX_DIGITS];
   logic [31:0]                     quot;
   logic [31:0]                     quot_times_ten;
   logic [3:0]                      rem;
   logic [3:0]                      text_len;
   logic [7:0]                      char_in;
   logic                            final_char;
   ifmt_pkg::rsp_type               rsp_ff;

   // Magnitude and sign of the incoming value.
   always_comb begin
      neg_in = (req_data.kind == ifmt_pkg::KIND_SIGNED) && req_data.value[31];
      val_in = neg_in ? (32'd0 - req_data.value) : req_data.value;
   end

   // Quotient and remainder of one digit step.
   assign product        = 64'(val_ff) * 64'(ifmt_pkg::RECIP_TEN);
   assign quot           = hex_ff ? {4'b0000, val_ff[31:4]}
                                  : 32'(quot_ff);
   assign quot_times_ten = (quot << 3) + (quot << 1);
   assign rem            = hex_ff ? val_ff[3:0] : 4'(val_ff - quot_times_ten);

   // Text length once the current digit is stored: digits plus the sign.
   assign text_len = nd_ff + 4'd1 + {3'b000, neg_ff};

   assign status.digits_done = (quot == 32'd0) ||
                               (nd_ff == 4'(ifmt_pkg::MAX_DIGITS - 1));

   // Character order: pad characters, then the sign, then digits high to low.
   assign final_char        = (pad_left_ff == 4'd0) && !neg_ff && (ptr_ff == 4'd0);
   assign status.final_char = final_char;

   always_comb begin
      if (pad_left_ff != 4'd0) begin
         char_in = zero_pad_ff ? ifmt_pkg::CHAR_ZERO : ifmt_pkg::CHAR_SPACE;
      end else if (neg_ff) begin
         char_in = ifmt_pkg::CHAR_MINUS;
      end else begin
         char_in = ifmt_pkg::digit_char(digit_ff[ptr_ff]);
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff      <= val_in;
         neg_ff      <= neg_in;
         hex_ff      <= (req_data.kind == ifmt_pkg::KIND_HEX);
         zero_pad_ff <= req_data.zero_pad;
         width_ff    <= (req_data.pad_width > 4'(ifmt_pkg::MAX_PAD)) ?
                        4'(ifmt_pkg::MAX_PAD) : req_data.pad_width;
         nd_ff       <= 4'd0;
      end
      if (cmd.mul) begin
         quot_ff <= product[63:ifmt_pkg::RECIP_SHIFT];
      end
      if (cmd.div) begin
         digit_ff[nd_ff] <= rem;
         val_ff          <= quot;
         nd_ff           <= nd_ff + 4'd1;
         ptr_ff          <= nd_ff;
         pad_left_ff     <= (width_ff > text_len) ? (width_ff - text_len) : 4'd0;
      end
      if (cmd.emit) begin
         if (pad_left_ff != 4'd0) begin
            pad_left_ff <= pad_left_ff - 4'd1;
         end else if (neg_ff) begin
            neg_ff <= 1'b0;
         end else if (ptr_ff != 4'd0) begin
            ptr_ff <= ptr_ff - 4'd1;
         end
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.out_char <= char_in;
         rsp_ff.last     <= final_char;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### hdl/integer_field_formatter.sv
// ----------------------------------------------------------------------------
// integer_field_formatter
// Formats a 32-bit value as signed decimal, unsigned decimal or lower-case
// hex text with optional padding, one ASCII character per output word.
// ----------------------------------------------------------------------------
// Usage: an input word on req_* carries the kind, value, field width (values
// above 9 count as 9) and the zero-pad flag. The field comes out on rsp_*
// as pad characters, an optional '-', then digits most significant first;
// last marks the final character. Pads go ahead of the minus sign.
// Timing: the block works on one word at a time. Each digit takes a
// multiply step (a registered reciprocal multiply, used only for decimal)
// and then the digit step, which stores the digit. The first character is
// registered in the emit state that follows the last digit step, once
// the output register is free.
// req_ready is high only between fields, but a new word is taken while the
// final character still waits in the output register.
// Stall: when rsp_ready is low the output word holds and emission pauses.
// Reset clears the controller and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module integer_field_formatter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ifmt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ifmt_pkg::rsp_type  rsp_data
);

   ifmt_pkg::cmd_type    cmd;
   ifmt_pkg::status_type status;

   // Sequencing and handshake control.
   ifmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Conversion arithmetic and the output word.
   ifmt_dpath u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

### tb/integer_field_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_formatter_tb
// The testbench first sends a table of directed words: zero, the extremes of
// each conversion, the spare kind code, field widths above the limit, and
// padding around a minus sign. A stream of random words follows. Every
// character that comes back is checked in order against the table text or,
// where that is blank, a local formatter. Both sides stall in random
// bursts. Once, the output side holds off for a long stretch so that the block has to stall its input.
// ----------------------------------------------------------------------------
module integer_field_formatter_tb;

   // The fourth kind code has no name in the package and converts as unsigned.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam int RANDOM_WORDS = 136;
   localparam int CALM_WORDS   = 25;
   localparam int HOLD_CYCLES  = 100;
   localparam int HOLD_AFTER   = 40;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 3000;

   typedef struct {
      ifmt_pkg::req_type word;
      string             text;
   } vector_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ifmt_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ifmt_pkg::rsp_type rsp_data;

   ifmt_pkg::rsp_type expected_chars[$];
   int                error_count      = 0;
   int                words_accepted   = 0;
   int                quiet_cycles     = 0;
   logic              calm_tail        = 1'b0;
   logic              receiver_holding = 1'b0;
   logic              hold_done        = 1'b0;

   // Directed words. A blank text means the local formatter supplies the field.
   vector_row_type directed_rows[24] = '{
      '{'{ifmt_pkg::KIND_SIGNED,   32'h0000_0000, 4'd0,  1'b0}, "0"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'h8000_0000, 4'd0,  1'b0}, "-2147483648"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'hFFFF_FFFF, 4'd0,  1'b0}, "-1"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'h7FFF_FFFF, 4'd0,  1'b0}, "2147483647"},
      '{'{ifmt_pkg::KIND_UNSIGNED, 32'hFFFF_FFFF, 4'd0,  1'b0}, "4294967295"},
      '{'{ifmt_pkg::KIND_HEX,      32'hFFFF_FFFF, 4'd0,  1'b0}, "ffffffff"},
      '{'{ifmt_pkg::KIND_HEX,      32'h0000_0000, 4'd0,  1'b1}, "0"},
      '{'{KIND_SPARE,              32'hFFFF_FFFF, 4'd0,  1'b0}, "4294967295"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'hFFFF_FFFB, 4'd9,  1'b1}, "0000000-5"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'hFFFF_FFFB, 4'd9,  1'b0}, "       -5"},
      '{'{ifmt_pkg::KIND_UNSIGNED, 32'd42,        4'd15, 1'b1}, "000000042"},
      '{'{ifmt_pkg::KIND_HEX,      32'h0000_0ABC, 4'd10, 1'b0}, "      abc"},
      '{'{ifmt_pkg::KIND_UNSIGNED, 32'd123,       4'd3,  1'b1}, "123"},
      '{'{ifmt_pkg::KIND_UNSIGNED, 32'd1234567,   4'd2,  1'b0}, "1234567"},
      '{'{ifmt_pkg::KIND_HEX,      32'hDEAD_BEEF, 4'd0,  1'b0}, "deadbeef"},
      '{'{ifmt_pkg::KIND_HEX,      32'h0123_4567, 4'd9,  1'b1}, "001234567"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'h8000_0000, 4'd9,  1'b1}, "-2147483648"},
      '{'{ifmt_pkg::KIND_UNSIGNED, 32'h0000_0000, 4'd9,  1'b0}, "        0"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'd12345,     4'd1,  1'b0}, ""},
      '{'{ifmt_pkg::KIND_HEX,      32'h89AB_CDEF, 4'd8,  1'b1}, ""},
      '{'{ifmt_pkg::KIND_UNSIGNED, 32'd1000000000, 4'd4, 1'b0}, "1000000000"},
      '{'{ifmt_pkg::KIND_SIGNED,   32'hFFFF_FF85, 4'd5,  1'b1}, "0-123"},
      '{'{KIND_SPARE,              32'd7,         4'd8,  1'b1}, ""},
      '{'{ifmt_pkg::KIND_SIGNED,   32'd5,         4'd4,  1'b0}, "   5"}
   };

   integer_field_formatter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Appends the characters of one formatted field to the expected stream.
   function automatic void format_field_chars(input ifmt_pkg::req_type word);
      logic [31:0]       magnitude;
      logic [31:0]       radix;
      logic [31:0]       digit;
      logic [7:0]        digits[0:9];
      logic [7:0]        field[0:10];
      logic              negative;
      int                width;
      int                digit_count;
      int                field_len;
      int                pad_count;
      int                i;
      ifmt_pkg::rsp_type char_word;

      width = (word.pad_width > ifmt_pkg::MAX_PAD) ? ifmt_pkg::MAX_PAD
                                                   : int'(word.pad_width);
      negative = (word.kind == ifmt_pkg::KIND_SIGNED) && word.value[31];
      magnitude = negative ? (32'd0 - word.value) : word.value;
      radix = (word.kind == ifmt_pkg::KIND_HEX) ? 32'd16 : 32'd10;

      // Digits come out least significant first.
      digit_count = 0;
      do begin
         digit = magnitude % radix;
         digits[digit_count] = (digit < 32'd10) ?
                               ifmt_pkg::CHAR_ZERO + digit[7:0] :
                               ifmt_pkg::CHAR_LOW_A + digit[7:0] - 8'd10;
         digit_count++;
         magnitude = magnitude / radix;
      end while (magnitude != 32'd0 && digit_count < ifmt_pkg::MAX_DIGITS);

      // Pads lead, even ahead of the minus sign.
      pad_count = 0;
      field_len = digit_count + (negative ? 1 : 0);
      if (field_len < width) begin
         pad_count = width - field_len;
      end
      for (i = 0; i < pad_count; i++) begin
         field[i] = word.zero_pad ? ifmt_pkg::CHAR_ZERO : ifmt_pkg::CHAR_SPACE;
      end
      field_len = pad_count;
      if (negative) begin
         field[field_len] = ifmt_pkg::CHAR_MINUS;
         field_len++;
      end
      for (i = digit_count - 1; i >= 0; i--) begin
         field[field_len] = digits[i];
         field_len++;
      end

      for (i = 0; i < field_len; i++) begin
         char_word.out_char = field[i];
         char_word.last = (i == field_len - 1);
         expected_chars.push_back(char_word);
      end
   endfunction

   // Offers one word, waits for it to be taken, then queues its characters.
   task automatic send_word(input ifmt_pkg::req_type word, input string text);
      ifmt_pkg::rsp_type char_word;
      int                i;

      if (!calm_tail && !receiver_holding && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (!req_ready);
      words_accepted++;
      if (text.len() == 0) begin
         format_field_chars(word);
      end else begin
         for (i = 0; i < text.len(); i++) begin
            char_word.out_char = text[i];
            char_word.last = (i == text.len() - 1);
            expected_chars.push_back(char_word);
         end
      end
      @(negedge clock);
   endtask

   // Output side: random stall bursts, one long hold-off, then always ready.
   initial begin
      @(negedge reset);
      forever begin
         if (!hold_done && words_accepted >= HOLD_AFTER) begin
            receiver_holding = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            receiver_holding = 1'b0;
            hold_done = 1'b1;
         end else if (calm_tail) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Compare each character taken from the block with the oldest expectation.
   always @(posedge clock) begin
      ifmt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected word: out_char %h last %b", rsp_data.out_char,
                   rsp_data.last);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.out_char !== want.out_char) begin
               $error("out_char: expected %h, actual %h", want.out_char,
                      rsp_data.out_char);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %b, actual %b", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int                i;
      ifmt_pkg::req_type word;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(directed_rows); i++) begin
         send_word(directed_rows[i].word, directed_rows[i].text);
      end

      // Random words, with values shaped toward edges and short fields.
      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i >= RANDOM_WORDS - CALM_WORDS) begin
            calm_tail = 1'b1;
         end
         word.kind = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: word.value = $urandom_range(0, 999);
            1: word.value = 32'd1 << $urandom_range(0, 31);
            2: word.value = 32'd0 - $urandom_range(1, 300);
            3: word.value = 32'h8000_0000 + $urandom_range(0, 3);
            default: word.value = $urandom;
         endcase
         word.pad_width = 4'($urandom_range(0, 15));
         word.zero_pad = 1'($urandom_range(0, 1));
         send_word(word, "");
      end
      req_valid <= 1'b0;

      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
hdl/ifmt_pkg.sv
hdl/ifmt_ctrl.sv
hdl/ifmt_dpath.sv
hdl/integer_field_formatter.sv
tb/integer_field_formatter_tb.sv
